// ===== rtl/core/tcc_pkg.sv =====
// Shared types and constants for the timer counter channel.
// Holds the item, result and configuration structs, the register map and
// the prescaler table. No dependencies.
package tcc_pkg;

  // Counter width in bits (8 to 32).
  localparam int COUNTER_WIDTH = 32;

  // Bus data, event flag, prescaler and configuration address widths.
  localparam int DATA_W     = 32;
  localparam int FLAG_W     = 4;
  localparam int PRESCALE_W = 7;
  localparam int CFG_ADDR_W = 3;

  // Item action codes; code 3 means nothing.
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  // Register map of the channel.
  localparam logic [3:0] REG_CTRL    = 4'd0;
  localparam logic [3:0] REG_MODE    = 4'd1;
  localparam logic [3:0] REG_MOTOR   = 4'd2;
  localparam logic [3:0] REG_VALUE   = 4'd3;
  localparam logic [3:0] REG_CMP_A   = 4'd4;
  localparam logic [3:0] REG_CMP_B   = 4'd5;
  localparam logic [3:0] REG_CMP_C   = 4'd6;
  localparam logic [3:0] REG_STATUS  = 4'd7;
  localparam logic [3:0] REG_IRQ_EN  = 4'd8;
  localparam logic [3:0] REG_IRQ_DIS = 4'd9;
  localparam logic [3:0] REG_MASK    = 4'd10;

  // Configuration register index.
  localparam logic CFG_WRITE_PROTECT = 1'b0;

  // Control and mode word bit positions.
  localparam int CTRL_CLKEN_BIT  = 0;
  localparam int CTRL_CLKDIS_BIT = 1;
  localparam int CTRL_SWTRG_BIT  = 2;
  localparam int MODE_WAVE_BIT   = 15;
  localparam int MOTOR_DOWN_BIT  = 1;
  localparam logic [2:0] CLKSEL_SLOW = 3'd4;

  // Event flag positions.
  localparam int EV_OVF = 0;
  localparam int EV_CPA = 1;
  localparam int EV_CPB = 2;
  localparam int EV_CPC = 3;

  // Master clock divisors and the prescaler value at which the counter steps.
  localparam int DIV_2   = 2;
  localparam int DIV_8   = 8;
  localparam int DIV_32  = 32;
  localparam int DIV_128 = 128;
  localparam logic [PRESCALE_W-1:0] PRESCALE_LAST [4] = '{
    PRESCALE_W'(DIV_2 - 1), PRESCALE_W'(DIV_8 - 1),
    PRESCALE_W'(DIV_32 - 1), PRESCALE_W'(DIV_128 - 1)
  };

  typedef struct packed {
    logic [1:0]        action;
    logic [3:0]        reg_index;
    logic [DATA_W-1:0] write_data;
    logic              slow_tick;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              access_error;
    logic [FLAG_W-1:0] irq_events;
  } result_t;

  typedef struct packed {
    logic write_protect;
  } cfg_t;

endpackage

// ===== rtl/core/tcc_if.sv =====
// Valid/ready channel interfaces for the timer counter channel.
// Depends on tcc_pkg for the payload widths.
interface tcc_in_if;
  import tcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [3:0]        reg_index;
  logic [DATA_W-1:0] write_data;
  logic              slow_tick;

  modport source (output valid, action, reg_index, write_data, slow_tick, input ready);
  modport sink (input valid, action, reg_index, write_data, slow_tick, output ready);
endinterface

interface tcc_out_if;
  import tcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              access_error;
  logic [FLAG_W-1:0] irq_events;

  modport source (output valid, read_data, access_error, irq_events, input ready);
  modport sink (input valid, read_data, access_error, irq_events, output ready);
endinterface

// ===== rtl/core/tcc_cfg.sv =====
// APB-style configuration port holding the write protect register.
// Depends on tcc_pkg.
module tcc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tcc_pkg::DATA_W-1:0]     pwdata,
  output logic [tcc_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  output tcc_pkg::cfg_t                  cfg
);
  import tcc_pkg::*;

  logic write_protect;
  logic reg_sel;

  // Word index of the access; alignment bits are ignored.
  assign reg_sel = paddr[CFG_ADDR_W-1];
  assign pready  = 1'b1;

  // The register is written in the access phase of a write.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_protect <= 1'b0;
    end else if (psel && penable && pwrite && reg_sel == CFG_WRITE_PROTECT) begin
      write_protect <= pwdata[0];
    end
  end

  // Read back; addresses beyond the register read as zero.
  always_comb begin
    prdata = '0;
    if (reg_sel == CFG_WRITE_PROTECT) begin
      prdata[0] = write_protect;
    end
  end

  assign cfg.write_protect = write_protect;

endmodule

// ===== rtl/core/tcc_core.sv =====
// Channel state and the combinational evaluation of one item.
// Computes the result and next state from the current state; state is
// updated when the item is fired into the result register. Depends on tcc_pkg.
module tcc_core (
  input  logic              clk,
  input  logic              rst,
  input  tcc_pkg::cfg_t     cfg,
  input  tcc_pkg::item_t    item,
  input  logic              fire,
  output tcc_pkg::result_t  result
);
  import tcc_pkg::*;

  localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

  logic [COUNTER_WIDTH-1:0] count_value, count_value_next;
  logic [DATA_W-1:0]        compare_a, compare_a_next;
  logic [DATA_W-1:0]        compare_b, compare_b_next;
  logic [DATA_W-1:0]        compare_c, compare_c_next;
  logic [DATA_W-1:0]        mode_word, mode_word_next;
  logic                     count_down, count_down_next;
  logic                     clock_active, clock_active_next;
  logic [FLAG_W-1:0]        pending_flags, pending_flags_next;
  logic [FLAG_W-1:0]        enable_mask, enable_mask_next;
  logic [PRESCALE_W-1:0]    prescale_count, prescale_count_next;

  logic [COUNTER_WIDTH-1:0] step_value;
  logic [FLAG_W-1:0]        step_raw;
  logic [FLAG_W-1:0]        step_events;
  logic [2:0]               clk_sel;
  logic                     wave;
  logic                     do_step;

  // One counter step, with its wrap and compare events.
  always_comb begin
    step_value       = count_down ? count_value - CNT_ONE : count_value + CNT_ONE;
    step_raw         = '0;
    step_raw[EV_OVF] = count_down ? (count_value == '0) : (count_value == '1);
    step_raw[EV_CPA] = (DATA_W'(step_value) == compare_a);
    step_raw[EV_CPB] = (DATA_W'(step_value) == compare_b);
    step_raw[EV_CPC] = (DATA_W'(step_value) == compare_c);
    step_events      = step_raw & enable_mask;
  end

  assign clk_sel = mode_word[2:0];
  assign wave    = mode_word[MODE_WAVE_BIT];

  // Item evaluation: result and next state.
  always_comb begin
    count_value_next    = count_value;
    compare_a_next      = compare_a;
    compare_b_next      = compare_b;
    compare_c_next      = compare_c;
    mode_word_next      = mode_word;
    count_down_next     = count_down;
    clock_active_next   = clock_active;
    pending_flags_next  = pending_flags;
    enable_mask_next    = enable_mask;
    prescale_count_next = prescale_count;
    result              = '0;
    do_step             = 1'b0;

    unique case (item.action)
      ACT_READ: begin
        unique case (item.reg_index)
          REG_MODE:  result.read_data = mode_word;
          REG_MOTOR: result.read_data[MOTOR_DOWN_BIT] = count_down;
          REG_VALUE: result.read_data = DATA_W'(count_value);
          REG_CMP_A: result.read_data = compare_a;
          REG_CMP_B: result.read_data = compare_b;
          REG_CMP_C: result.read_data = compare_c;
          REG_STATUS: begin
            result.read_data[FLAG_W-1:0] = pending_flags & enable_mask;
            pending_flags_next = '0;
          end
          REG_MASK:  result.read_data[FLAG_W-1:0] = enable_mask;
          default:   result.access_error = 1'b1;
        endcase
      end
      ACT_WRITE: begin
        unique case (item.reg_index)
          REG_CTRL: begin
            // Software trigger wins, then disable over enable.
            priority if (item.write_data[CTRL_SWTRG_BIT]) begin
              clock_active_next   = 1'b1;
              count_value_next    = '0;
              prescale_count_next = '0;
            end else if (item.write_data[CTRL_CLKDIS_BIT]) begin
              clock_active_next   = 1'b0;
              prescale_count_next = '0;
            end else if (item.write_data[CTRL_CLKEN_BIT]) begin
              clock_active_next   = 1'b1;
              prescale_count_next = '0;
            end else begin
              // No control bit set: the clock and prescaler are left alone.
            end
          end
          REG_MODE: begin
            if (cfg.write_protect) result.access_error = 1'b1;
            else mode_word_next = item.write_data;
          end
          REG_MOTOR: begin
            if (cfg.write_protect) result.access_error = 1'b1;
            else count_down_next = item.write_data[MOTOR_DOWN_BIT];
          end
          REG_CMP_A: begin
            if (cfg.write_protect || !wave) result.access_error = 1'b1;
            else compare_a_next = item.write_data;
          end
          REG_CMP_B: begin
            if (cfg.write_protect || !wave) result.access_error = 1'b1;
            else compare_b_next = item.write_data;
          end
          REG_CMP_C: begin
            if (cfg.write_protect) result.access_error = 1'b1;
            else compare_c_next = item.write_data;
          end
          REG_IRQ_EN:  enable_mask_next = enable_mask | item.write_data[FLAG_W-1:0];
          REG_IRQ_DIS: enable_mask_next = enable_mask & ~item.write_data[FLAG_W-1:0];
          default:     result.access_error = 1'b1;
        endcase
      end
      ACT_TICK: begin
        // Master clock through the prescaler, or the slow clock; others are off.
        if (clock_active) begin
          if (clk_sel < CLKSEL_SLOW) begin
            if (prescale_count >= PRESCALE_LAST[clk_sel[1:0]]) begin
              prescale_count_next = '0;
              do_step = 1'b1;
            end else begin
              prescale_count_next = prescale_count + PRESCALE_W'(1);
            end
          end else if (clk_sel == CLKSEL_SLOW && item.slow_tick) begin
            do_step = 1'b1;
          end
        end
        if (do_step) begin
          count_value_next   = step_value;
          pending_flags_next = pending_flags | step_events;
          result.irq_events  = step_events;
        end
      end
      default: begin
        // Unused action code: no effect.
      end
    endcase
  end

  // State update on each fired item.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_value    <= '0;
      compare_a      <= '0;
      compare_b      <= '0;
      compare_c      <= '0;
      mode_word      <= '0;
      count_down     <= 1'b0;
      clock_active   <= 1'b0;
      pending_flags  <= '0;
      enable_mask    <= '0;
      prescale_count <= '0;
    end else if (fire) begin
      count_value    <= count_value_next;
      compare_a      <= compare_a_next;
      compare_b      <= compare_b_next;
      compare_c      <= compare_c_next;
      mode_word      <= mode_word_next;
      count_down     <= count_down_next;
      clock_active   <= clock_active_next;
      pending_flags  <= pending_flags_next;
      enable_mask    <= enable_mask_next;
      prescale_count <= prescale_count_next;
    end
  end

endmodule

// ===== rtl/core/timer_counter_channel.sv =====
// Timer counter channel: top level with input and result registers.
// Depends on tcc_pkg, tcc_if, tcc_cfg and tcc_core.
//
// Items (bus read, bus write or one master clock tick) arrive on in_chan,
// results (read data, access error, raised event flags) leave on out_chan;
// both are valid/ready channels and each transfer is one item.
// Every item gives exactly one result, in order. An item is held in the
// input register, evaluated against the channel state and written to the
// result register, from which its result is offered on out_chan. One item
// is accepted every cycle while out_chan does not stall, as a single
// evaluation path lies between the input and result registers.
// When out_chan stalls, the result register holds and one more item waits
// in the input register; in_chan.ready then drops until the result moves.
// The write protect register sits behind the APB port at address 0; the user
// writes it only while no item is in flight, which the block does not enforce.
// Reset (rst, synchronous) empties both registers and returns all channel
// state to zero: counter stopped, counting up, no flags enabled.
module timer_counter_channel (
  input  logic                           clk,
  input  logic                           rst,
  tcc_in_if.sink                         in_chan,
  tcc_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tcc_pkg::DATA_W-1:0]     pwdata,
  output logic [tcc_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import tcc_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  result_t core_result;
  result_t out_result;
  logic    out_valid;
  logic    out_free;
  logic    fire;

  tcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (s1_item),
    .fire   (fire),
    .result (core_result)
  );

  // Flow control between the two registers.
  assign out_free      = !out_valid || out_chan.ready;
  assign fire          = s1_valid && out_free;
  assign in_chan.ready = !s1_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_item <= '{action:     in_chan.action,
                   reg_index:  in_chan.reg_index,
                   write_data: in_chan.write_data,
                   slow_tick:  in_chan.slow_tick};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= core_result;
    end
  end

  assign out_chan.valid        = out_valid;
  assign out_chan.read_data    = out_result.read_data;
  assign out_chan.access_error = out_result.access_error;
  assign out_chan.irq_events   = out_result.irq_events;

`ifndef ASSERT_OFF
  // A waiting item is not dropped while the result side stalls.
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_chan.ready) |=> s1_valid)
    else $error("item lost while result stalled");

  // Only tick items can raise event flags.
  a_events_from_tick: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_item.action != ACT_TICK) |=> (out_chan.irq_events == '0))
    else $error("event flags raised by a register access");

  // A refused access returns no data.
  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_chan.access_error) |-> (out_chan.read_data == '0))
    else $error("read data on a refused access");
`endif

endmodule

// ===== tb/tb_timer_counter_channel.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the timer counter channel: directed and random items,
// an in-order prediction of every result and burst/stall traffic on both channels.
// Depends on tcc_pkg, the tcc_in_if/tcc_out_if interfaces and timer_counter_channel.
module tb_timer_counter_channel;
  import tcc_pkg::*;

  // Action code with no effect and the last unused register index.
  localparam logic [1:0] ACT_NONE     = 2'd3;
  localparam logic [3:0] REG_LAST     = 4'd15;
  // Clock select codes besides the package's slow clock entry.
  localparam logic [2:0] CLKSEL_DIV2  = 3'd0;
  localparam logic [2:0] CLKSEL_OFF   = 3'd7;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic pready;

  tcc_in_if  in_chan ();
  tcc_out_if out_chan ();

  timer_counter_channel dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow copy of the channel state and the write protect setting.
  logic [DATA_W-1:0]     tm_count, tm_cmp_a, tm_cmp_b, tm_cmp_c, tm_mode;
  logic                  tm_down, tm_running, tm_protect;
  logic [FLAG_W-1:0]     tm_pending, tm_irq_en;
  logic [PRESCALE_W-1:0] tm_presc;

  result_t predicted_results [$];
  int      err_count = 0;
  int      cycle_cnt = 0;
  int      burst_left = 0;
  bit      gaps_off = 1'b0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  logic [9:0] rx_cnt = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One counter clock: step, detect wrap and compare hits, latch enabled flags.
  function automatic logic [FLAG_W-1:0] counter_step();
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] cur;
    logic [FLAG_W-1:0] ev;
    top = DATA_W'((64'd1 << COUNTER_WIDTH) - 64'd1);
    ev  = '0;
    cur = tm_count & top;
    if (tm_down) begin
      if (cur == '0) begin
        cur = top;
        ev[EV_OVF] = 1'b1;
      end else begin
        cur = cur - 1'b1;
      end
    end else begin
      if (cur == top) begin
        cur = '0;
        ev[EV_OVF] = 1'b1;
      end else begin
        cur = cur + 1'b1;
      end
    end
    tm_count = cur;
    if (cur == tm_cmp_a) ev[EV_CPA] = 1'b1;
    if (cur == tm_cmp_b) ev[EV_CPB] = 1'b1;
    if (cur == tm_cmp_c) ev[EV_CPC] = 1'b1;
    ev = ev & tm_irq_en;
    tm_pending = tm_pending | ev;
    return ev;
  endfunction

  // Works out the result of one accepted item and advances the shadow state.
  function automatic result_t timer_predict(input item_t it);
    result_t           r;
    logic [2:0]        sel;
    logic [DATA_W-1:0] d;
    int                div;
    r   = '0;
    d   = it.write_data;
    sel = tm_mode[2:0];
    case (it.action)
      ACT_READ: begin
        case (it.reg_index)
          REG_MODE:   r.read_data = tm_mode;
          REG_MOTOR:  r.read_data[MOTOR_DOWN_BIT] = tm_down;
          REG_VALUE:  r.read_data = tm_count;
          REG_CMP_A:  r.read_data = tm_cmp_a;
          REG_CMP_B:  r.read_data = tm_cmp_b;
          REG_CMP_C:  r.read_data = tm_cmp_c;
          REG_STATUS: begin
            r.read_data[FLAG_W-1:0] = tm_pending & tm_irq_en;
            tm_pending = '0;
          end
          REG_MASK:   r.read_data[FLAG_W-1:0] = tm_irq_en;
          default:    r.access_error = 1'b1;
        endcase
      end
      ACT_WRITE: begin
        case (it.reg_index)
          REG_CTRL: begin
            // Software trigger wins, then disable, then enable.
            if (d[CTRL_SWTRG_BIT]) begin
              tm_running = 1'b1;
              tm_count   = '0;
              tm_presc   = '0;
            end else if (d[CTRL_CLKDIS_BIT]) begin
              tm_running = 1'b0;
              tm_presc   = '0;
            end else if (d[CTRL_CLKEN_BIT]) begin
              tm_running = 1'b1;
              tm_presc   = '0;
            end
          end
          REG_MODE:    if (tm_protect) r.access_error = 1'b1; else tm_mode = d;
          REG_MOTOR:   if (tm_protect) r.access_error = 1'b1; else tm_down = d[MOTOR_DOWN_BIT];
          REG_CMP_A: begin
            if (tm_protect || !tm_mode[MODE_WAVE_BIT]) r.access_error = 1'b1;
            else tm_cmp_a = d;
          end
          REG_CMP_B: begin
            if (tm_protect || !tm_mode[MODE_WAVE_BIT]) r.access_error = 1'b1;
            else tm_cmp_b = d;
          end
          REG_CMP_C:   if (tm_protect) r.access_error = 1'b1; else tm_cmp_c = d;
          REG_IRQ_EN:  tm_irq_en = tm_irq_en | d[FLAG_W-1:0];
          REG_IRQ_DIS: tm_irq_en = tm_irq_en & ~d[FLAG_W-1:0];
          default:     r.access_error = 1'b1;
        endcase
      end
      ACT_TICK: begin
        if (tm_running) begin
          if (sel < CLKSEL_SLOW) begin
            // Divisors are 2, 8, 32 and 128; a smaller one applies at once.
            div = DIV_2 << (2 * sel);
            if (int'(tm_presc) + 1 >= div) begin
              tm_presc = '0;
              r.irq_events = counter_step();
            end else begin
              tm_presc = tm_presc + 1'b1;
            end
          end else if (sel == CLKSEL_SLOW && it.slow_tick) begin
            r.irq_events = counter_step();
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result checking against the oldest prediction, then prediction of any accepted item.
  always @(posedge clk) begin
    result_t want;
    item_t   it;
    if (!rst) begin
      if (out_chan.valid && out_chan.ready) begin
        if (predicted_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result rd %h err %b irq %h", $time,
                   out_chan.read_data, out_chan.access_error, out_chan.irq_events);
        end else begin
          want = predicted_results.pop_front();
          if (out_chan.read_data !== want.read_data) begin
            err_count++;
            $display("%0t: read_data expected %h actual %h", $time,
                     want.read_data, out_chan.read_data);
          end
          if (out_chan.access_error !== want.access_error) begin
            err_count++;
            $display("%0t: access_error expected %b actual %b", $time,
                     want.access_error, out_chan.access_error);
          end
          if (out_chan.irq_events !== want.irq_events) begin
            err_count++;
            $display("%0t: irq_events expected %h actual %h", $time,
                     want.irq_events, out_chan.irq_events);
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        it.action     = in_chan.action;
        it.reg_index  = in_chan.reg_index;
        it.write_data = in_chan.write_data;
        it.slow_tick  = in_chan.slow_tick;
        predicted_results.push_back(timer_predict(it));
      end
    end
  end

  // Receiver: a long hold-off when asked, otherwise a rotating stall pattern.
  always @(negedge clk) begin
    rx_cnt <= rx_cnt + 1'b1;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_chan.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else begin
      case (rx_cnt[9:7])
        3'd0, 3'd4: out_chan.ready <= 1'b1;
        3'd1, 3'd5: out_chan.ready <= ($urandom_range(0, 3) != 0);
        3'd2:       out_chan.ready <= ($urandom_range(0, 3) == 0);
        default:    out_chan.ready <= (rx_cnt[2:0] != 3'd0);
      endcase
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one item and holds it until the transfer, then idles between bursts.
  task automatic send_item(input logic [1:0] act, input logic [3:0] idx,
                           input logic [DATA_W-1:0] data, input logic slow);
    int gap;
    in_chan.valid      <= 1'b1;
    in_chan.action     <= act;
    in_chan.reg_index  <= idx;
    in_chan.write_data <= data;
    in_chan.slow_tick  <= slow;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
      gap = $urandom_range(0, 6);
      if (!gaps_off && gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Stops offering items and lets every outstanding result arrive.
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (predicted_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write of the write protect register, setup then access; only while idle.
  task automatic set_write_protect(input logic value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * CFG_WRITE_PROTECT);
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tm_protect = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reads and writes that must be refused, a valid counter read and an unused action code.
  task automatic test_access_errors();
    send_item(ACT_READ,  REG_CTRL,  '0, 1'b0);
    send_item(ACT_READ,  REG_VALUE, '0, 1'b0);
    send_item(ACT_READ,  REG_LAST,  '0, 1'b1);
    send_item(ACT_WRITE, REG_VALUE, 32'h0000_0001, 1'b0);
    send_item(ACT_NONE,  REG_STATUS, '1, 1'b1);
    send_item(ACT_WRITE, REG_CMP_A, 32'h0000_0001, 1'b0);
  endtask

  // Counting at the fastest divisor: trigger, control precedence, compares and wrap.
  task automatic test_count_events();
    send_item(ACT_WRITE, REG_MODE,   DATA_W'(1 << MODE_WAVE_BIT) | CLKSEL_DIV2, 1'b0);
    send_item(ACT_WRITE, REG_CMP_A,  '1, 1'b0);
    send_item(ACT_WRITE, REG_CMP_B,  32'h0000_0001, 1'b0);
    send_item(ACT_WRITE, REG_CMP_C,  '0, 1'b0);
    send_item(ACT_WRITE, REG_IRQ_EN, '1, 1'b0);
    send_item(ACT_WRITE, REG_CTRL,   32'h0000_0007, 1'b0);
    repeat (2) send_item(ACT_TICK, REG_CTRL, '0, 1'b0);
    send_item(ACT_WRITE, REG_MOTOR,  DATA_W'(1 << MOTOR_DOWN_BIT), 1'b0);
    send_item(ACT_WRITE, REG_CTRL,   32'h0000_0003, 1'b0);
    send_item(ACT_WRITE, REG_CTRL,   32'h0000_0001, 1'b0);
    // Down onto zero and compare C, then wrap onto compare A.
    repeat (4) send_item(ACT_TICK, REG_CTRL, '0, 1'b1);
    send_item(ACT_READ,  REG_STATUS, '0, 1'b0);
    send_item(ACT_WRITE, REG_MODE,   DATA_W'(1 << MODE_WAVE_BIT) | CLKSEL_OFF, 1'b0);
    send_item(ACT_TICK,  REG_CTRL,   '0, 1'b1);
  endtask

  // Protected writes are refused, the waveform flag notwithstanding.
  task automatic test_protected_writes();
    send_item(ACT_WRITE, REG_MODE,  '0, 1'b0);
    send_item(ACT_WRITE, REG_CMP_A, 32'h0000_0010, 1'b0);
    send_item(ACT_WRITE, REG_CMP_C, 32'h0000_0010, 1'b0);
  endtask

  // Random traffic: mostly ticks, meaningful writes and reads, with some noise.
  task automatic test_random(input int count);
    int                r;
    int                w;
    logic [3:0]        idx;
    logic [DATA_W-1:0] data;
    repeat (count) begin
      r    = $urandom_range(0, 99);
      data = $urandom;
      if (r < 55) begin
        send_item(ACT_TICK, 4'($urandom), data, 1'($urandom));
      end else if (r < 77) begin
        w = $urandom_range(0, 9);
        case (w)
          0, 9: begin
            idx = REG_CTRL;
            w = $urandom_range(0, 9);
            if (w < 4) data[2:0] = 3'b001;
            else if (w < 6) data[2:0] = 3'b100;
            else if (w < 7) data[2:0] = 3'b010;
          end
          1: begin
            idx = REG_MODE;
            data[MODE_WAVE_BIT] = ($urandom_range(0, 3) != 0);
            w = $urandom_range(0, 9);
            if (w < 3) data[2:0] = CLKSEL_DIV2;
            else if (w < 5) data[2:0] = CLKSEL_SLOW;
          end
          2: idx = REG_MOTOR;
          3, 4, 5: begin
            idx = REG_CMP_A + 4'(w - 3);
            w = $urandom_range(0, 4);
            if (w < 2) data = DATA_W'($urandom_range(0, 40));
            else if (w < 4) data = '1 - DATA_W'($urandom_range(0, 40));
          end
          6: idx = REG_IRQ_EN;
          7: idx = ($urandom_range(0, 2) == 0) ? REG_IRQ_DIS : REG_IRQ_EN;
          default: idx = 4'($urandom);
        endcase
        send_item(ACT_WRITE, idx, data, 1'($urandom));
      end else if (r < 95) begin
        w = $urandom_range(0, 3);
        idx = (w == 0) ? REG_STATUS : (w == 1) ? REG_VALUE : 4'($urandom);
        send_item(ACT_READ, idx, data, 1'($urandom));
      end else begin
        send_item(2'($urandom), 4'($urandom), data, 1'($urandom));
      end
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming back to back.
  task automatic test_backpressure();
    gaps_off = 1'b1;
    hold_req = 1'b1;
    test_random(60);
    gaps_off = 1'b0;
  endtask

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_chan.valid      = 1'b0;
    in_chan.action     = ACT_READ;
    in_chan.reg_index  = REG_CTRL;
    in_chan.write_data = '0;
    in_chan.slow_tick  = 1'b0;
    out_chan.ready     = 1'b0;
    tm_count   = '0;
    tm_cmp_a   = '0;
    tm_cmp_b   = '0;
    tm_cmp_c   = '0;
    tm_mode    = '0;
    tm_down    = 1'b0;
    tm_running = 1'b0;
    tm_protect = 1'b0;
    tm_pending = '0;
    tm_irq_en  = '0;
    tm_presc   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_access_errors();
    test_count_events();
    set_write_protect(1'b1);
    test_protected_writes();
    test_random(400);
    set_write_protect(1'b0);
    test_random(700);
    test_backpressure();
    test_random(200);
    set_write_protect(1'b1);
    test_random(250);
    set_write_protect(1'b0);
    test_random(250);

    drain();
    repeat (10) @(negedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
